// ===== rtl/dashed_line_rasterizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DASHED_LINE_RASTERIZER_TOP_ASSERT_SVH
`define DASHED_LINE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer package
// Shared widths, codes, flag struct and the modulo-3 helper.
// ----------------------------------------------------------------------------
package dlr_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEF = 12;

  // Configuration register and result address widths.
  localparam int REG_W  = 13;
  localparam int ADDR_W = 24;

  // Configuration register reset values.
  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SURFACE_WIDTH  = 1'b0;
  localparam logic REG_SURFACE_HEIGHT = 1'b1;

  // Dash pattern: period of three points, the plotted phase is the last one.
  localparam int         DASH_PERIOD = 3;
  localparam logic [1:0] PHASE_PLOT  = 2'd2;

  // Flags that travel with a point from the walker to the address stage.
  typedef struct packed {
    logic valid;
    logic dash_hit;
    logic last;
  } dlr_pt_flags_t;

  // Remainder by three: base-4 digits sum to the same residue, then fold twice.
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [3:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    s2 = 4'(s[4:2]) + 4'(s[1:0]);
    s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
    return (s3 >= 3'(DASH_PERIOD)) ? 2'(s3 - 3'(DASH_PERIOD)) : s3[1:0];
  endfunction

endpackage

// ===== rtl/dlr_if.sv =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer channels
// Command channel (load or step) and pixel result channel.
// ----------------------------------------------------------------------------
interface dlr_cmd_if
  import dlr_pkg::*;
#(
  parameter int CoordBits = COORD_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [CoordBits-1:0] x_start;
  logic [CoordBits-1:0] y_start;
  logic [CoordBits-1:0] x_end;
  logic [CoordBits-1:0] y_end;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dlr_pix_if
  import dlr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pixel_address;
  logic              plot;
  logic              last_point;

  modport source (output valid, pixel_address, plot, last_point, input ready);
  modport sink   (input valid, pixel_address, plot, last_point, output ready);
endinterface

// ===== rtl/dlr_walker.sv =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer walker
// Holds the Bresenham state and dash phase, emits one point per step request.
// ----------------------------------------------------------------------------
module dlr_walker
  import dlr_pkg::*;
#(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 take,
  input  logic                 opcode,
  input  logic [CoordBits-1:0] x_start,
  input  logic [CoordBits-1:0] y_start,
  input  logic [CoordBits-1:0] x_end,
  input  logic [CoordBits-1:0] y_end,
  output logic [CoordBits-1:0] pt_x,
  output logic [CoordBits-1:0] pt_y,
  output dlr_pt_flags_t        pt_flags
);

  localparam int ErrW = CoordBits + 2;

  logic [CoordBits-1:0] cur_x, cur_y, goal_x, goal_y, abs_dx, abs_dy;
  logic                 dir_x_negative, dir_y_negative;
  logic signed [ErrW-1:0] error_term;
  logic [1:0]           dash_phase;
  logic                 active;

  logic [CoordBits-1:0]   load_dx, load_dy;
  logic signed [ErrW-1:0] load_err;
  logic [1:0]             load_phase;
  logic signed [ErrW-1:0] dx_s, dy_s;
  logic [1:0]             phase_next;
  logic                   at_end, move_x, move_y;
  logic signed [ErrW-1:0] err_next;
  logic [CoordBits-1:0]   x_next, y_next;

  // Line setup from the endpoints.
  always_comb begin
    load_dx    = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
    load_dy    = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
    load_err   = (load_dx > load_dy) ? signed'(ErrW'(load_dx >> 1))
                                     : -signed'(ErrW'(load_dy >> 1));
    load_phase = mod3_16(16'(y_end));
  end

  // One Bresenham step and the dash phase advance.
  always_comb begin
    dx_s       = signed'(ErrW'(abs_dx));
    dy_s       = signed'(ErrW'(abs_dy));
    phase_next = (dash_phase == 2'(DASH_PERIOD - 1)) ? 2'd0 : dash_phase + 2'd1;
    at_end     = (cur_x == goal_x) && (cur_y == goal_y);
    move_x     = error_term > -dx_s;
    move_y     = error_term < dy_s;
    err_next   = error_term - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
    x_next     = dir_x_negative ? cur_x - CoordBits'(1) : cur_x + CoordBits'(1);
    y_next     = dir_y_negative ? cur_y - CoordBits'(1) : cur_y + CoordBits'(1);
  end

  // Walker state and the point register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      dash_phase     <= 2'd0;
      pt_flags.valid <= 1'b0;
    end else if (en) begin
      // Only a step request produces a point.
      pt_flags.valid <= take && (opcode == OP_STEP);
      if (take) begin
        if (opcode == OP_LOAD) begin
          cur_x          <= x_start;
          cur_y          <= y_start;
          goal_x         <= x_end;
          goal_y         <= y_end;
          abs_dx         <= load_dx;
          abs_dy         <= load_dy;
          dir_x_negative <= !(x_start < x_end);
          dir_y_negative <= !(y_start < y_end);
          error_term     <= load_err;
          dash_phase     <= load_phase;
          active         <= 1'b1;
        end else if (!active) begin
          // Idle step reports the origin, never plotted, flagged last.
          pt_flags.dash_hit <= 1'b0;
          pt_flags.last     <= 1'b1;
          pt_x              <= '0;
          pt_y              <= '0;
        end else begin
          pt_flags.dash_hit <= (phase_next == PHASE_PLOT);
          pt_flags.last     <= at_end;
          pt_x              <= cur_x;
          pt_y              <= cur_y;
          dash_phase        <= phase_next;
          if (at_end) begin
            active <= 1'b0;
          end else begin
            error_term <= err_next;
            if (move_x) begin
              cur_x <= x_next;
            end
            if (move_y) begin
              cur_y <= y_next;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/dlr_addr.sv =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer address stage
// Forms y*width+x and the surface size, then the bound test and result register.
// ----------------------------------------------------------------------------
module dlr_addr
  import dlr_pkg::*;
#(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [CoordBits-1:0] pt_x,
  input  logic [CoordBits-1:0] pt_y,
  input  dlr_pt_flags_t        pt_flags,
  input  logic [REG_W-1:0]     surface_width,
  input  logic [REG_W-1:0]     surface_height,
  output logic                 valid,
  output logic [ADDR_W-1:0]    pixel_address,
  output logic                 plot,
  output logic                 last_point
);

  localparam int FullW = CoordBits + REG_W + 1;
  localparam int LimW  = 2 * REG_W;
  localparam int CmpW  = (FullW > LimW) ? FullW : LimW;
  localparam int ExtW  = (FullW > ADDR_W) ? FullW : ADDR_W;

  logic [FullW-1:0] addr_full;
  logic [LimW-1:0]  limit;
  dlr_pt_flags_t    mid_flags;

  logic             in_bounds;
  logic [ExtW-1:0]  addr_ext;

  // Product stage: address and surface size in parallel multipliers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_flags.valid <= 1'b0;
    end else if (en) begin
      mid_flags <= pt_flags;
      addr_full <= FullW'(pt_y) * FullW'(surface_width) + FullW'(pt_x);
      limit     <= LimW'(surface_width) * LimW'(surface_height);
    end
  end

  // Bound test on the full address; the result carries the low bits.
  always_comb begin
    in_bounds = CmpW'(addr_full) < CmpW'(limit);
    addr_ext  = ExtW'(addr_full);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid         <= mid_flags.valid;
      pixel_address <= addr_ext[ADDR_W-1:0];
      plot          <= mid_flags.dash_hit & in_bounds;
      last_point    <= mid_flags.last;
    end
  end

endmodule

// ===== rtl/dashed_line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer top level
// Bresenham walker with a one-in-three dash, giving linear pixel addresses.
//
//   channel | role   | carries
//   --------+--------+-------------------------------------------------
//   cmd     | sink   | opcode, x_start, y_start, x_end, y_end
//   pix     | source | pixel_address, plot, last_point (one per step)
//   cfg_*   | write  | surface_width (index 0), surface_height (index 1)
//
// One request is taken every cycle while the pipe advances; a step result
// passes the walker register, multiplier register and result register.
// The three stages advance together whenever the result register is empty
// or being taken, so a stalled result holds the whole pipe and cmd.ready.
// Synchronous reset clears the walker's active flag, all stage valids and
// restores width 640 and height 480.
// ----------------------------------------------------------------------------
module dashed_line_rasterizer_top
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  dlr_cmd_if.sink          cmd,
  dlr_pix_if.source        pix
);

  logic [REG_W-1:0]      surface_width, surface_height;
  logic                  en, take;
  logic [COORD_BITS-1:0] pt_x, pt_y;
  dlr_pt_flags_t         pt_flags;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= WIDTH_RESET;
      surface_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        REG_SURFACE_HEIGHT: surface_height <= cfg_data;
        default:            surface_width  <= surface_width;
      endcase
    end
  end

  // Pipeline advance and request acceptance.
  assign en        = !pix.valid || pix.ready;
  assign cmd.ready = en;
  assign take      = cmd.valid && en;

  dlr_walker #(
    .CoordBits (COORD_BITS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .take     (take),
    .opcode   (cmd.opcode),
    .x_start  (cmd.x_start),
    .y_start  (cmd.y_start),
    .x_end    (cmd.x_end),
    .y_end    (cmd.y_end),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_flags (pt_flags)
  );

  dlr_addr #(
    .CoordBits (COORD_BITS)
  ) u_addr (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .pt_x           (pt_x),
    .pt_y           (pt_y),
    .pt_flags       (pt_flags),
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .valid          (pix.valid),
    .pixel_address  (pix.pixel_address),
    .plot           (pix.plot),
    .last_point     (pix.last_point)
  );

endmodule

// ===== rtl/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// Dashed line rasterizer port checker
// Watches the top-level channels for stall, flow and latency behavior.
// ----------------------------------------------------------------------------
`include "dashed_line_rasterizer_top_assert.svh"

module dlr_checker
  import dlr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              cmd_opcode,
  input logic              pix_valid,
  input logic              pix_ready,
  input logic [ADDR_W-1:0] pix_pixel_address,
  input logic              pix_plot,
  input logic              pix_last_point
);

  // A stalled result keeps its valid and its payload.
  `DLR_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_pixel_address) && $stable(pix_plot) && $stable(pix_last_point), "pix result changed while stalled")

  // An empty result register never blocks requests.
  `DLR_ASSERT_NOW(a_cmd_ready_free, !pix_valid, cmd_ready, "cmd not ready with empty output")

  // A stalled result holds back new requests.
  `DLR_ASSERT_NOW(a_cmd_stall, pix_valid && !pix_ready, !cmd_ready, "cmd ready while pix stalled")

  // A step request reaches the output if the result side stays ready meanwhile.
  `DLR_ASSERT_NEXT(a_step_latency, cmd_valid && cmd_ready && cmd_opcode == OP_STEP ##1 pix_ready ##1 pix_ready, pix_valid, "step result missing after three cycles")

endmodule

bind dashed_line_rasterizer_top dlr_checker u_dlr_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .cmd_opcode        (cmd.opcode),
  .pix_valid         (pix.valid),
  .pix_ready         (pix.ready),
  .pix_pixel_address (pix.pixel_address),
  .pix_plot          (pix.plot),
  .pix_last_point    (pix.last_point)
);

// ===== test/dlr_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dashed line rasterizer pixel checker
// Watches the command, result and register-write ports, walks its own copy
// of the dashed Bresenham line for every accepted request, and compares each
// accepted pixel result with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module dlr_pixel_checker
  import dlr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  dlr_cmd_if               cmd,
  dlr_pix_if               pix,
  output int               fail_count,
  output int               pending
);

  localparam int CB = COORD_BITS_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              plot;
    logic              last;
  } pixel_t;

  // Shadow copy of the surface registers.
  logic [REG_W-1:0] surf_w;
  logic [REG_W-1:0] surf_h;

  // Shadow copy of the line walker.
  logic [CB-1:0] pos_x, pos_y, end_x, end_y, span_x, span_y;
  logic          back_x, back_y;
  int            err;
  logic [1:0]    dash;
  logic          line_live;

  // Pixels predicted but not yet seen on the result port.
  pixel_t expected_pixels[$];

  // Work out the pixel, if any, that one accepted request produces.
  task automatic walk_request(input logic op, input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                              input logic [CB-1:0] xe, input logic [CB-1:0] ye);
    pixel_t     px;
    longint     addr;
    longint     bound;
    logic       at_end;
    int         e2;
    if (op == OP_LOAD) begin
      pos_x     = xs;
      pos_y     = ys;
      end_x     = xe;
      end_y     = ye;
      span_x    = (xe >= xs) ? xe - xs : xs - xe;
      span_y    = (ye >= ys) ? ye - ys : ys - ye;
      back_x    = !(xs < xe);
      back_y    = !(ys < ye);
      err       = (span_x > span_y) ? int'(span_x >> 1) : -int'(span_y >> 1);
      dash      = 2'(ye % 3);
      line_live = 1'b1;
    end else if (!line_live) begin
      // A step with no line loaded reports an idle end point.
      px.addr = '0;
      px.plot = 1'b0;
      px.last = 1'b1;
      expected_pixels.push_back(px);
    end else begin
      addr   = longint'(pos_y) * longint'(surf_w) + longint'(pos_x);
      bound  = longint'(surf_w) * longint'(surf_h);
      at_end = (pos_x == end_x) && (pos_y == end_y);
      dash   = (dash == 2'd2) ? 2'd0 : dash + 2'd1;
      px.addr = addr[ADDR_W-1:0];
      px.plot = (dash == PHASE_PLOT) && (addr < bound);
      px.last = at_end;
      expected_pixels.push_back(px);
      if (at_end) begin
        line_live = 1'b0;
      end else begin
        // One Bresenham step; both axes may move on the same point.
        e2 = err;
        if (e2 > -int'(span_x)) begin
          err   = err - int'(span_y);
          pos_x = back_x ? pos_x - 1'b1 : pos_x + 1'b1;
        end
        if (e2 < int'(span_y)) begin
          err   = err + int'(span_x);
          pos_y = back_y ? pos_y - 1'b1 : pos_y + 1'b1;
        end
      end
    end
  endtask

  // Compare one accepted pixel with the oldest prediction.
  task automatic compare_pixel(input logic [ADDR_W-1:0] addr, input logic plot,
                               input logic last);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("pixel result with no request waiting: address %0d", addr);
      fail_count++;
    end else begin
      want = expected_pixels.pop_front();
      if (addr !== want.addr) begin
        $error("pixel_address mismatch: expected %0d, actual %0d", want.addr, addr);
        fail_count++;
      end
      if (plot !== want.plot) begin
        $error("plot mismatch: expected %0d, actual %0d", want.plot, plot);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("last_point mismatch: expected %0d, actual %0d", want.last, last);
        fail_count++;
      end
    end
  endtask

  // Sample every port at the rising edge, before the driver's updates land.
  always @(posedge clk) begin
    if (rst) begin
      surf_w    = WIDTH_RESET;
      surf_h    = HEIGHT_RESET;
      pos_x     = '0;
      pos_y     = '0;
      end_x     = '0;
      end_y     = '0;
      span_x    = '0;
      span_y    = '0;
      back_x    = 1'b0;
      back_y    = 1'b0;
      err       = 0;
      dash      = 2'd0;
      line_live = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SURFACE_WIDTH) begin
          surf_w = cfg_data;
        end else begin
          surf_h = cfg_data;
        end
      end
      if (pix.valid && pix.ready) begin
        compare_pixel(pix.pixel_address, pix.plot, pix.last_point);
      end
      if (cmd.valid && cmd.ready) begin
        walk_request(cmd.opcode, cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end);
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dashed line rasterizer testbench
// Drives directed lines and then random dashed lines through the command
// port under three idling mixes and one long result stall, changes the
// surface size between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import dlr_pkg::*;

  localparam int CB            = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int MAX_COORD     = (1 << CB) - 1;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [REG_W-1:0] cfg_data;

  dlr_cmd_if #(.CoordBits(CB)) cmd_ch ();
  dlr_pix_if                   pix_ch ();

  int fail_count;
  int pending;
  int cycle_count;
  int items_sent;
  int snd_idle_pct;
  int rcv_idle_pct;
  int cur_w;
  int cur_h;
  bit hold_req;

  dashed_line_rasterizer_top #(.COORD_BITS(CB)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .pix       (pix_ch)
  );

  dlr_pixel_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd_ch),
    .pix        (pix_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    pix_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pix_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      pix_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic op, input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                              input logic [CB-1:0] xe, input logic [CB-1:0] ye);
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= op;
    cmd_ch.x_start <= xs;
    cmd_ch.y_start <= ys;
    cmd_ch.x_end   <= xe;
    cmd_ch.y_end   <= ye;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  // Step requests carry random coordinates, which the block ignores.
  task automatic send_step();
    send_request(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  task automatic trace_line(input int xs, input int ys, input int xe, input int ye,
                            input int steps);
    send_request(OP_LOAD, CB'(xs), CB'(ys), CB'(xe), CB'(ye));
    repeat (steps) send_step();
  endtask

  // Points on a line, end point included.
  function automatic int line_points(input int xs, input int ys, input int xe, input int ye);
    int dx;
    int dy;
    dx = (xs > xe) ? xs - xe : xe - xs;
    dy = (ys > ye) ? ys - ye : ye - ys;
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  function automatic int near_coord(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return v;
  endfunction

  function automatic int surface_coord(input int extent);
    int top;
    top = (extent > MAX_COORD + 1) ? MAX_COORD + 1 : extent;
    return int'($urandom_range(top - 1));
  endfunction

  // Wait until every predicted pixel has come out and the pipe has drained.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_surface(input int w, input int h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SURFACE_WIDTH;
    cfg_data  <= REG_W'(w);
    @(posedge clk);
    cfg_index <= REG_SURFACE_HEIGHT;
    cfg_data  <= REG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w  = w;
    cur_h  = h;
  endtask

  // Mostly complete lines near the surface, with cut lines, idle steps
  // and fully random loads mixed in.
  task automatic run_random(input int count);
    int first;
    int kind;
    int spread;
    int xs, ys, xe, ye;
    int steps;
    first = items_sent;
    while (items_sent - first < count) begin
      kind = $urandom_range(99);
      if (kind < 78) begin
        spread = ($urandom_range(99) < 2) ? 300 : (($urandom_range(99) < 15) ? 40 : 8);
        if ($urandom_range(1) == 1) begin
          xs = surface_coord(cur_w);
          ys = surface_coord(cur_h);
        end else begin
          xs = $urandom_range(MAX_COORD);
          ys = $urandom_range(MAX_COORD);
        end
        xe = near_coord(xs, spread);
        ye = near_coord(ys, spread);
        steps = line_points(xs, ys, xe, ye);
        if ($urandom_range(99) < 8) begin
          // Cut the line short so the next load lands on a live line.
          steps = $urandom_range(steps);
        end else if ($urandom_range(99) < 12) begin
          steps = steps + $urandom_range(1, 2);
        end
        trace_line(xs, ys, xe, ye, steps);
      end else if (kind < 88) begin
        send_step();
      end else begin
        trace_line($urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                   $urandom_range(MAX_COORD), $urandom_range(MAX_COORD), $urandom_range(4));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_SURFACE_WIDTH;
    cfg_data       = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.opcode  = OP_LOAD;
    cmd_ch.x_start = '0;
    cmd_ch.y_start = '0;
    cmd_ch.x_end   = '0;
    cmd_ch.y_end   = '0;
    items_sent     = 0;
    hold_req       = 1'b0;
    cur_w          = int'(WIDTH_RESET);
    cur_h          = int'(HEIGHT_RESET);
    snd_idle_pct   = 18;
    rcv_idle_pct   = 57;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed lines on the reset surface.
    send_step();                                 // step with no line loaded
    trace_line(0, 0, 0, 0, 2);                   // single point, then idle step
    trace_line(MAX_COORD, MAX_COORD, MAX_COORD - 2, MAX_COORD - 1, 3);  // both axes backward
    trace_line(10, 20, 12, 20, 1);               // horizontal, replaced while live
    trace_line(5, 5, 5, 7, 3);                   // vertical
    trace_line(0, 479, 2, 477, 3);               // diagonal at the bottom row

    // Full coordinate-range surface, smallest surface, then an empty surface.
    set_surface(4096, 4096);
    trace_line(MAX_COORD, MAX_COORD, MAX_COORD - 1, MAX_COORD, 2);
    set_surface(1, 1);
    trace_line(0, 0, 1, 0, 2);
    set_surface(0, 5);
    trace_line(0, 0, 0, 2, 3);

    // Random phase, sender idles lightly and the receiver heavily.
    set_surface($urandom_range(1, 64), $urandom_range(1, 64));
    run_random(520);

    // Random phase, the other way round.
    settle();
    snd_idle_pct = 57;
    rcv_idle_pct = 18;
    set_surface(4096, 1);
    run_random(520);

    // Random phase with no idling and one long result stall.
    settle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_surface($urandom_range(1, 4096), $urandom_range(1, 4096));
    run_random(150);
    hold_req = 1'b1;
    run_random(370);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dlr_pkg.sv
rtl/dlr_if.sv
rtl/dlr_walker.sv
rtl/dlr_addr.sv
rtl/dashed_line_rasterizer_top.sv
rtl/dlr_checker.sv
test/dlr_pixel_checker.sv
test/tb_top.sv
